// ===== hw/rtl/cjtg_pkg.sv =====
// Shared types and constants for the cubic joint trajectory generator.
package cjtg_pkg;

    // Number of joints handled by the block.
    localparam int NJ = 5;

    // Command codes of an input item.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DURATION = 3'd0;
    localparam logic [2:0] CFG_TARGET0  = 3'd1;

    // Reset value of the duration register, in microseconds.
    localparam logic [31:0] DUR_RESET = 32'd1000000;

    // Unity in Q1.30, three in Q2.30 and the velocity scale (6 * 10^6 us/s).
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
    localparam logic [22:0] VEL_SCALE = 23'd6000000;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;

    // Input item.
    typedef struct packed {
        logic        cmd;
        logic [31:0] now_us;
        logic        measured_valid;
        logic [31:0] measured_pos_0;
        logic [31:0] measured_pos_1;
        logic [31:0] measured_pos_2;
        logic [31:0] measured_pos_3;
        logic [31:0] measured_pos_4;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic        finished;
        logic [31:0] desired_pos_0;
        logic [31:0] desired_pos_1;
        logic [31:0] desired_pos_2;
        logic [31:0] desired_pos_3;
        logic [31:0] desired_pos_4;
        logic [31:0] desired_vel_0;
        logic [31:0] desired_vel_1;
        logic [31:0] desired_vel_2;
        logic [31:0] desired_vel_3;
        logic [31:0] desired_vel_4;
    } out_item_t;

    // A classified tick waiting for the back end.
    typedef struct packed {
        logic        finished;
        logic [31:0] elapsed;
        logic [31:0] duration;
    } job_t;

endpackage

// ===== hw/rtl/cubic_joint_trajectory_gen.sv =====
// Rest-to-rest cubic trajectory generator for five joints: top level.
//
// Input channel (in_valid/in_stall/in_item): a start item stores the start
// time and, if measured_valid is set, the start positions and displacements;
// it gives no result; a tick gives one result on out_valid/out_stall/out_item.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not check.
// A start item is taken once no tick is queued or in work. A tick past the
// duration leaves the queue straight for the done state, which loads the
// output register when it is free. A tick in motion leaves the queue, then
// passes a divider for s = e/T, three multiply steps, a summing step and a
// division for velocity in five lanes, then the output register. The back
// end takes the next tick only once it is back in idle. Ticks queue two deep
// in front of the back end, so the input keeps taking ticks while a result
// waits on a stalled output, until the queue is full.
// At reset the duration is 1000000 us, targets and stored state are zero,
// and the queue and output register are empty.
// A stalled receiver holds the result in the output register; the back end
// then waits, and the input stalls once the queue is full.
module cubic_joint_trajectory_gen #(
    parameter int POS_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  cjtg_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output cjtg_pkg::out_item_t out_item
);
    import cjtg_pkg::*;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;
    job_t                 push_job;
    job_t                 pop_job;
    logic                 back_busy;
    logic [NJ-1:0][31:0]  start_pos;
    logic [NJ-1:0][32:0]  disp;
    logic [NJ-1:0][31:0]  target;

    cjtg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .back_busy (back_busy),
        .q_empty   (q_empty),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .start_pos (start_pos),
        .disp      (disp),
        .target    (target)
    );

    cjtg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    cjtg_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .start_pos (start_pos),
        .disp      (disp),
        .target    (target),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("tick pushed into a full queue");

    // A start only changes the stored state while no tick is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_item.cmd == CMD_START)) |-> (!back_busy && q_empty))
        else $error("start accepted while ticks are pending");

    // A finished result holds zero velocity on every joint.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.finished) |->
        ((out_item.desired_vel_0 == '0) && (out_item.desired_vel_1 == '0) &&
         (out_item.desired_vel_2 == '0) && (out_item.desired_vel_3 == '0) &&
         (out_item.desired_vel_4 == '0)))
        else $error("finished result with nonzero velocity");

    // The queue is popped only when it holds an entry.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/cjtg_front.sv =====
// Front end: configuration registers, start handling and tick classification.
module cjtg_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  cjtg_pkg::in_item_t                 in_item,
    input  logic                               back_busy,
    input  logic                               q_empty,
    input  logic                               q_full,
    output logic                               q_push,
    output cjtg_pkg::job_t                     q_job,
    output logic [cjtg_pkg::NJ-1:0][31:0]      start_pos,
    output logic [cjtg_pkg::NJ-1:0][32:0]      disp,
    output logic [cjtg_pkg::NJ-1:0][31:0]      target
);
    import cjtg_pkg::*;

    logic [31:0]          dur_reg, dur_next;
    logic [NJ-1:0][31:0]  tgt_reg, tgt_next;
    logic [NJ-1:0][31:0]  sp_reg, sp_next;
    logic [NJ-1:0][32:0]  disp_reg, disp_next;
    logic [31:0]          st_reg, st_next;
    logic [NJ-1:0][31:0]  meas;
    logic                 accept;
    logic [31:0]          elapsed;
    logic [31:0]          dur_eff;

    assign meas[0] = in_item.measured_pos_0;
    assign meas[1] = in_item.measured_pos_1;
    assign meas[2] = in_item.measured_pos_2;
    assign meas[3] = in_item.measured_pos_3;
    assign meas[4] = in_item.measured_pos_4;

    // A start waits until no tick is queued or in work; a tick waits for queue room.
    assign in_stall = (in_item.cmd == CMD_START) ? (back_busy || !q_empty) : q_full;
    assign accept   = in_valid && !in_stall;

    // Classify a tick: elapsed time wraps, a zero duration counts as one.
    assign elapsed        = in_item.now_us - st_reg;
    assign dur_eff        = (dur_reg == 32'd0) ? 32'd1 : dur_reg;
    assign q_push         = accept && (in_item.cmd == CMD_TICK);
    assign q_job.finished = elapsed > dur_eff;
    assign q_job.elapsed  = elapsed;
    assign q_job.duration = dur_eff;

    // Configuration writes and start items update the stored state.
    always_comb
    begin
        dur_next  = dur_reg;
        tgt_next  = tgt_reg;
        sp_next   = sp_reg;
        disp_next = disp_reg;
        st_next   = st_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_DURATION)
            begin
                dur_next = cfg_data;
            end
            for (int j = 0; j < NJ; j++)
            begin
                if (cfg_index == CFG_TARGET0 + 3'(j))
                begin
                    tgt_next[j] = cfg_data;
                end
            end
        end
        if (accept && (in_item.cmd == CMD_START))
        begin
            st_next = in_item.now_us;
            if (in_item.measured_valid)
            begin
                for (int j = 0; j < NJ; j++)
                begin
                    sp_next[j]   = meas[j];
                    disp_next[j] = 33'($signed({tgt_reg[j][31], tgt_reg[j]})
                                   - $signed({meas[j][31], meas[j]}));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg  <= DUR_RESET;
            tgt_reg  <= '0;
            sp_reg   <= '0;
            disp_reg <= '0;
            st_reg   <= '0;
        end
        else
        begin
            dur_reg  <= dur_next;
            tgt_reg  <= tgt_next;
            sp_reg   <= sp_next;
            disp_reg <= disp_next;
            st_reg   <= st_next;
        end
    end

    assign start_pos = sp_reg;
    assign disp      = disp_reg;
    assign target    = tgt_reg;

endmodule

// ===== hw/rtl/cjtg_queue.sv =====
// Short queue of classified ticks between front and back end.
module cjtg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cjtg_pkg::job_t push_job,
    input  logic           pop,
    output cjtg_pkg::job_t pop_job,
    output logic           empty,
    output logic           full
);
    import cjtg_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    job_t                mem_reg [QDEPTH];
    logic [PW-1:0]       wp_reg, wp_next;
    logic [PW-1:0]       rp_reg, rp_next;
    logic [PW:0]         cnt_reg, cnt_next;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (PW+1)'(QDEPTH));
    assign pop_job = mem_reg[rp_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/cjtg_back.sv =====
// Back end: divider, polynomial evaluation, per-joint lanes and result register.
module cjtg_back #(
    parameter int POS_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  cjtg_pkg::job_t                     q_job,
    output logic                               q_pop,
    input  logic [cjtg_pkg::NJ-1:0][31:0]      start_pos,
    input  logic [cjtg_pkg::NJ-1:0][32:0]      disp,
    input  logic [cjtg_pkg::NJ-1:0][31:0]      target,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cjtg_pkg::out_item_t                out_item
);
    import cjtg_pkg::*;

    localparam int PBITS = (POS_WIDTH < 32) ? POS_WIDTH : 32;
    localparam logic signed [33:0] PMAX = 34'((64'sd1 <<< (PBITS - 1)) - 64'sd1);
    localparam logic signed [33:0] PMIN = -PMAX - 34'sd1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV_S = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_MUL3  = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_DIV_V = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 fin_reg, fin_next;
    logic [31:0]          t_reg, t_next;
    logic [32:0]          drem_reg, drem_next;
    logic [30:0]          s_reg, s_next;
    logic [30:0]          s2_reg, s2_next;
    logic [31:0]          w_reg, w_next;
    logic [28:0]          g_reg, g_next;
    logic [30:0]          h_reg, h_next;
    logic [51:0]          g6_reg, g6_next;
    logic [NJ-1:0][31:0]  step_reg, step_next;
    logic [NJ-1:0][57:0]  plo_reg, plo_next;
    logic [NJ-1:0][57:0]  phi_reg, phi_next;
    logic [NJ-1:0][31:0]  posr_reg, posr_next;
    logic [NJ-1:0][32:0]  vrem_reg, vrem_next;
    logic [NJ-1:0][31:0]  vlow_reg, vlow_next;
    logic [NJ-1:0][31:0]  q_reg, q_next;
    logic [NJ-1:0]        ovf_reg, ovf_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 out_free;
    logic                 ds_ge;
    logic [32:0]          ds_diff;
    logic [61:0]          prod_ss;
    logic [61:0]          prod_g;
    logic [30:0]          one_minus_s;
    logic [62:0]          prod_h;
    logic [NJ-1:0]        neg;
    logic [NJ-1:0][31:0]  mag;
    logic [NJ-1:0][32:0]  mag33;
    logic [NJ-1:0][62:0]  prod_step;
    logic [NJ-1:0][83:0]  nsum;
    logic [NJ-1:0][53:0]  nq;
    logic [NJ-1:0][33:0]  pos34;
    logic [NJ-1:0][32:0]  vsh;
    logic [NJ-1:0]        v_ge;
    logic [NJ-1:0][31:0]  vmag;
    logic [NJ-1:0][31:0]  vel;

    // Saturate a wide position to the configured position range.
    function automatic logic [31:0] clamp_pos(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = v;
        if (v > PMAX)
        begin
            r = PMAX;
        end
        else if (v < PMIN)
        begin
            r = PMIN;
        end
        return r[31:0];
    endfunction

    // Sign and magnitude of each stored displacement.
    always_comb
    begin
        for (int j = 0; j < NJ; j++)
        begin
            neg[j]   = disp[j][32];
            mag33[j] = neg[j] ? (33'd0 - disp[j]) : disp[j];
            mag[j]   = mag33[j][31:0];
        end
    end

    // Datapath terms of the shared unit.
    assign ds_ge       = drem_reg >= {1'b0, t_reg};
    assign ds_diff     = ds_ge ? (drem_reg - {1'b0, t_reg}) : drem_reg;
    assign prod_ss     = s_reg * s_reg;
    assign one_minus_s = ONE_Q30 - s_reg;
    assign prod_g      = s_reg * one_minus_s;
    assign prod_h      = s2_reg * w_reg;

    // Datapath terms of the joint lanes.
    always_comb
    begin
        for (int j = 0; j < NJ; j++)
        begin
            prod_step[j] = mag[j] * h_reg;
            nsum[j]      = {26'd0, plo_reg[j]} + {phi_reg[j], 26'd0};
            nq[j]        = nsum[j][83:30];
            pos34[j]     = $signed({{2{start_pos[j][31]}}, start_pos[j]})
                           + (neg[j] ? -$signed({2'b00, step_reg[j]})
                                     : $signed({2'b00, step_reg[j]}));
            vsh[j]       = {vrem_reg[j][31:0], vlow_reg[j][31]};
            v_ge[j]      = vsh[j] >= {1'b0, t_reg};
            vmag[j]      = (ovf_reg[j] || (q_reg[j] > 32'h8000_0000)) ? 32'h8000_0000
                                                                      : q_reg[j];
            if (fin_reg)
            begin
                vel[j] = '0;
            end
            else if (neg[j])
            begin
                vel[j] = 32'd0 - vmag[j];
            end
            else
            begin
                vel[j] = vmag[j][31] ? 32'h7FFF_FFFF : vmag[j];
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign busy     = (state_reg != ST_IDLE);

    // Sequencer and register next values.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        t_next         = t_reg;
        drem_next      = drem_reg;
        s_next         = s_reg;
        s2_next        = s2_reg;
        w_next         = w_reg;
        g_next         = g_reg;
        h_next         = h_reg;
        g6_next        = g6_reg;
        step_next      = step_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        posr_next      = posr_reg;
        vrem_next      = vrem_reg;
        vlow_next      = vlow_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    t_next    = q_job.duration;
                    fin_next  = q_job.finished;
                    drem_next = {1'b0, q_job.elapsed};
                    s_next    = '0;
                    cnt_next  = '0;
                    if (q_job.finished)
                    begin
                        for (int j = 0; j < NJ; j++)
                        begin
                            posr_next[j] = clamp_pos($signed({{2{target[j][31]}}, target[j]}));
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV_S;
                    end
                end
            end
            ST_DIV_S:
            begin
                // One quotient bit of s = e * 2^30 / T per cycle.
                s_next    = {s_reg[29:0], ds_ge};
                drem_next = {ds_diff[31:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'd30)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                s2_next    = prod_ss[60:30];
                w_next     = THREE_Q30 - {s_reg, 1'b0};
                g_next     = prod_g[58:30];
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                h_next     = prod_h[60:30];
                g6_next    = g_reg * VEL_SCALE;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                for (int j = 0; j < NJ; j++)
                begin
                    step_next[j] = prod_step[j][61:30];
                    plo_next[j]  = mag[j] * g6_reg[25:0];
                    phi_next[j]  = mag[j] * g6_reg[51:26];
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // Combine partial products and prepare the velocity division.
                for (int j = 0; j < NJ; j++)
                begin
                    posr_next[j] = clamp_pos(pos34[j]);
                    vrem_next[j] = {11'd0, nq[j][53:32]};
                    vlow_next[j] = nq[j][31:0];
                    ovf_next[j]  = {10'd0, nq[j][53:32]} >= t_reg;
                    q_next[j]    = '0;
                end
                cnt_next   = '0;
                state_next = ST_DIV_V;
            end
            ST_DIV_V:
            begin
                for (int j = 0; j < NJ; j++)
                begin
                    vrem_next[j] = v_ge[j] ? (vsh[j] - {1'b0, t_reg}) : vsh[j];
                    vlow_next[j] = {vlow_reg[j][30:0], 1'b0};
                    q_next[j]    = {q_reg[j][30:0], v_ge[j]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.finished       = fin_reg;
                    out_item_next.desired_pos_0  = posr_reg[0];
                    out_item_next.desired_pos_1  = posr_reg[1];
                    out_item_next.desired_pos_2  = posr_reg[2];
                    out_item_next.desired_pos_3  = posr_reg[3];
                    out_item_next.desired_pos_4  = posr_reg[4];
                    out_item_next.desired_vel_0  = vel[0];
                    out_item_next.desired_vel_1  = vel[1];
                    out_item_next.desired_vel_2  = vel[2];
                    out_item_next.desired_vel_3  = vel[3];
                    out_item_next.desired_vel_4  = vel[4];
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        fin_reg      <= fin_next;
        t_reg        <= t_next;
        drem_reg     <= drem_next;
        s_reg        <= s_next;
        s2_reg       <= s2_next;
        w_reg        <= w_next;
        g_reg        <= g_next;
        h_reg        <= h_next;
        g6_reg       <= g6_next;
        step_reg     <= step_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        posr_reg     <= posr_next;
        vrem_reg     <= vrem_next;
        vlow_reg     <= vlow_next;
        q_reg        <= q_next;
        ovf_reg      <= ovf_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the cubic joint trajectory generator.
`timescale 1ns / 100ps

module tb_top;
    import cjtg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;

    // Shadow copy of the block's registers and trajectory state.
    logic [31:0] shadow_duration;
    longint      shadow_target [NJ];
    longint      traj_start_pos [NJ];
    longint      traj_disp [NJ];
    logic [31:0] traj_start_time;

    out_item_t   pending_results [$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_burst = 0;
    int          idle_cycles = 0;

    cubic_joint_trajectory_gen DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Saturate a signed value to 32 bits.
    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expected result of a tick at time now.
    function automatic out_item_t trajectory_point(logic [31:0] now);
        longint unsigned t, e, s, s2, h, g, mag, stp, m, a, r, tot;
        longint          pos, vmag;
        logic [31:0]     el;
        logic [31:0]     pv [NJ];
        logic [31:0]     vv [NJ];
        bit              neg;
        out_item_t       o;
        t  = (shadow_duration == 0) ? 64'd1 : {32'd0, shadow_duration};
        el = now - traj_start_time;
        e  = {32'd0, el};
        o  = '0;
        if (e > t) begin
            o.finished = 1'b1;
            for (int j = 0; j < NJ; j++)
            begin
                pv[j] = sat32(shadow_target[j]);
                vv[j] = '0;
            end
        end else begin
            s  = (e << 30) / t;
            s2 = (s * s) >> 30;
            h  = (s2 * (3 * (64'd1 << 30) - 2 * s)) >> 30;
            g  = (s * ((64'd1 << 30) - s)) >> 30;
            for (int j = 0; j < NJ; j++)
            begin
                neg = traj_disp[j] < 0;
                mag = neg ? -traj_disp[j] : traj_disp[j];
                stp = (mag * h) >> 30;
                pos = traj_start_pos[j] + (neg ? -longint'(stp) : longint'(stp));
                m   = mag * g;
                a   = m / t;
                r   = m % t;
                if (a >= (64'd1 << 40)) begin
                    vmag = 64'sd2147483648;
                end else begin
                    tot  = (a * 6000000 + (r * 6000000) / t) >> 30;
                    vmag = (tot > 64'd2147483648) ? 64'sd2147483648 : longint'(tot);
                end
                pv[j] = sat32(pos);
                vv[j] = sat32(neg ? -vmag : vmag);
            end
        end
        o.desired_pos_0 = pv[0]; o.desired_pos_1 = pv[1]; o.desired_pos_2 = pv[2];
        o.desired_pos_3 = pv[3]; o.desired_pos_4 = pv[4];
        o.desired_vel_0 = vv[0]; o.desired_vel_1 = vv[1]; o.desired_vel_2 = vv[2];
        o.desired_vel_3 = vv[3]; o.desired_vel_4 = vv[4];
        return o;
    endfunction

    // Update the shadow state for an accepted item and queue its result.
    task automatic track_item(in_item_t it);
        logic [31:0] mp [NJ];
        mp[0] = it.measured_pos_0; mp[1] = it.measured_pos_1; mp[2] = it.measured_pos_2;
        mp[3] = it.measured_pos_3; mp[4] = it.measured_pos_4;
        if (it.cmd == CMD_START) begin
            if (it.measured_valid) begin
                for (int j = 0; j < NJ; j++)
                begin
                    traj_start_pos[j] = longint'($signed(mp[j]));
                    traj_disp[j]      = shadow_target[j] - traj_start_pos[j];
                end
            end
            traj_start_time = it.now_us;
        end else begin
            pending_results.push_back(trajectory_point(it.now_us));
        end
    endtask

    // Offer one item, with an occasional gap before it, and wait for acceptance.
    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_item(it);
    endtask

    // Lower valid and wait until every result has come and the block is idle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all registers; the block must be idle.
    task automatic write_regs(logic [31:0] dur, logic [31:0] tg [NJ]);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DURATION;
        cfg_data  <= dur;
        @(posedge clk);
        shadow_duration = dur;
        for (int j = 0; j < NJ; j++)
        begin
            cfg_index <= CFG_TARGET0 + 3'(j);
            cfg_data  <= tg[j];
            @(posedge clk);
            shadow_target[j] = longint'($signed(tg[j]));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t make_start(logic [31:0] now, bit valid);
        in_item_t it;
        it = '0;
        it.cmd = CMD_START;
        it.now_us = now;
        it.measured_valid = valid;
        it.measured_pos_0 = $urandom; it.measured_pos_1 = $urandom;
        it.measured_pos_2 = $urandom; it.measured_pos_3 = $urandom;
        it.measured_pos_4 = $urandom;
        return it;
    endfunction

    function automatic in_item_t make_tick(logic [31:0] now);
        in_item_t it;
        it = make_start(now, 1'($urandom));
        it.cmd = CMD_TICK;
        return it;
    endfunction

    // Tick time at a chosen point of the current trajectory.
    function automatic logic [31:0] pick_time;
        longint unsigned t, e;
        t = (shadow_duration == 0) ? 64'd1 : {32'd0, shadow_duration};
        case ($urandom_range(0, 9))
            0: e = 0;
            1: e = t;
            2: e = t + 1;
            3: e = $urandom;
            4: e = t / 2;
            default: e = {32'd0, $urandom} % (t + 1);
        endcase
        return traj_start_time + e[31:0];
    endfunction

    function automatic logic [31:0] pick_duration;
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            3: return 32'd1000000;
            4: return $urandom;
            default: return $urandom_range(2, 5000);
        endcase
    endfunction

    // Compare one field of a result.
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("finished", 32'(e.finished), 32'(out_item.finished));
                check_field("desired_pos_0", e.desired_pos_0, out_item.desired_pos_0);
                check_field("desired_pos_1", e.desired_pos_1, out_item.desired_pos_1);
                check_field("desired_pos_2", e.desired_pos_2, out_item.desired_pos_2);
                check_field("desired_pos_3", e.desired_pos_3, out_item.desired_pos_3);
                check_field("desired_pos_4", e.desired_pos_4, out_item.desired_pos_4);
                check_field("desired_vel_0", e.desired_vel_0, out_item.desired_vel_0);
                check_field("desired_vel_1", e.desired_vel_1, out_item.desired_vel_1);
                check_field("desired_vel_2", e.desired_vel_2, out_item.desired_vel_2);
                check_field("desired_vel_3", e.desired_vel_3, out_item.desired_vel_3);
                check_field("desired_vel_4", e.desired_vel_4, out_item.desired_vel_4);
            end
        end
    end

    // Receiver stalls: random bursts, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(1, 5) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Ticks on the reset state, before any start.
    task automatic test_before_start;
        send_item(make_tick(32'd0));
        send_item(make_tick(32'd500000));
        send_item(make_tick(32'd1000000));
        send_item(make_tick(32'd1000001));
        send_item(make_tick(32'hFFFF_FFFF));
        drain();
    endtask

    // Extreme targets and positions, key instants, wrap and invalid start.
    task automatic test_directed;
        logic [31:0] tg [NJ];
        in_item_t    it;
        tg = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
        write_regs(32'd1000, tg);
        it = make_start(32'hFFFF_FF00, 1'b1);
        it.measured_pos_0 = 32'h8000_0000;
        it.measured_pos_1 = 32'h7FFF_FFFF;
        it.measured_pos_2 = 32'h0;
        send_item(it);
        send_item(make_tick(32'hFFFF_FF00));
        send_item(make_tick(32'hFFFF_FF00 + 32'd500));
        send_item(make_tick(32'hFFFF_FF00 + 32'd1000));
        send_item(make_tick(32'hFFFF_FF00 + 32'd1001));
        send_item(make_tick(32'hFFFF_FE00));
        // An invalid start keeps positions but restarts the clock.
        send_item(make_start(32'd10, 1'b0));
        send_item(make_tick(32'd260));
        drain();
        // Zero duration behaves as one microsecond.
        write_regs(32'd0, tg);
        send_item(make_start(32'd0, 1'b1));
        send_item(make_tick(32'd0));
        send_item(make_tick(32'd1));
        send_item(make_tick(32'd2));
        drain();
        // A target changed after start shows up only once finished.
        tg = '{32'h1234_5678, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        write_regs(32'hFFFF_FFFF, tg);
        send_item(make_start(32'd5, 1'b1));
        drain();
        tg = '{32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555};
        write_regs(32'hFFFF_FFFF, tg);
        send_item(make_tick(32'h8000_0004));
        send_item(make_tick(32'd4));
        send_item(make_tick(32'd6));
        drain();
    endtask

    // Random phases of start and tick sequences under new settings.
    task automatic test_random(int phases, int items_per_phase);
        logic [31:0] tg [NJ];
        int          sent;
        for (int p = 0; p < phases; p++)
        begin
            for (int j = 0; j < NJ; j++)
                tg[j] = $urandom;
            write_regs(pick_duration(), tg);
            sent = 0;
            while (sent < items_per_phase)
            begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any command at any time.
                    if ($urandom_range(0, 1))
                        send_item(make_tick($urandom));
                    else
                        send_item(make_start($urandom, 1'($urandom)));
                    sent++;
                end else begin
                    send_item(make_start($urandom, $urandom_range(0, 9) != 0));
                    sent++;
                    repeat ($urandom_range(3, 12))
                    begin
                        send_item(make_tick(pick_time()));
                        sent++;
                    end
                end
            end
            drain();
        end
    endtask

    // Long receiver hold-off while ticks keep coming, then a full pause.
    task automatic test_backpressure;
        send_item(make_start($urandom, 1'b1));
        hold_req = 1'b1;
        repeat (12) send_item(make_tick(pick_time()));
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (8) send_item(make_tick(pick_time()));
        drain();
    endtask

    initial
    begin
        for (int j = 0; j < NJ; j++)
        begin
            shadow_target[j]  = 0;
            traj_start_pos[j] = 0;
            traj_disp[j]      = 0;
        end
        shadow_duration = DUR_RESET;
        traj_start_time = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_start();
        test_directed();
        test_random(10, 130);
        test_backpressure();
        quiet = 1'b1;
        test_random(2, 120);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cjtg_pkg.sv
hw/rtl/cjtg_front.sv
hw/rtl/cjtg_queue.sv
hw/rtl/cjtg_back.sv
hw/rtl/cubic_joint_trajectory_gen.sv
bench/tb_top.sv
